[design/piano_note_interval_tracker_macros.svh]
// ----------------------------------------------------------------------------
// Piano note interval tracker: assertion macros
// Short forms for clocked assertions, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef PIANO_NOTE_INTERVAL_TRACKER_MACROS_SVH
`define PIANO_NOTE_INTERVAL_TRACKER_MACROS_SVH

// Condition that must hold at every edge outside reset
`define PNIT_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the next
`define PNIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pnit_pkg.sv]
// ----------------------------------------------------------------------------
// Piano note interval tracker package
// Field widths, register map, reset values and default parameters.
// ----------------------------------------------------------------------------
package pnit_pkg;

    localparam int NUM_PITCHES_DEF = 88;
    localparam int FRAME_BITS_DEF  = 20;

    localparam int PITCH_W     = 7;
    localparam int PROB_W      = 8;
    localparam int VEL_W       = 7;
    localparam int OUT_FRAME_W = 20;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    typedef enum logic [1:0] {
        REG_PROB_THRESHOLD  = 2'd0,
        REG_VELOCITY_SCALE  = 2'd1,
        REG_VELOCITY_OFFSET = 2'd2
    } t_reg_idx;

    localparam logic [PROB_W-1:0] THRESHOLD_RST = 8'd128;
    localparam logic [VEL_W-1:0]  SCALE_RST     = 7'd80;
    localparam logic [VEL_W-1:0]  OFFSET_RST    = 7'd10;
    localparam logic [VEL_W-1:0]  VEL_MAX       = 7'd127;

endpackage

[design/piano_note_interval_tracker.sv]
// A finished note is registered in the input stage, then in the result register.
// Throughput: one item per cycle; the input stage stalls only while it has a note to
// deliver and the result register is full and not being taken.
// Reset (synchronous, active low): registers to reset values, all notes inactive,
// frame counter zero. Start/velocity memories are not cleared: entries are used only
// for active pitches, which have always been written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Piano note interval tracker
// Turns a frame-major stream of per-pitch onset/frame/volume probabilities into
// finished notes (pitch, start frame, end frame, velocity).
// ----------------------------------------------------------------------------
module piano_note_interval_tracker #(
    parameter int NUM_PITCHES = pnit_pkg::NUM_PITCHES_DEF,
    parameter int FRAME_BITS  = pnit_pkg::FRAME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pnit_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pnit_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pnit_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_start_of_piece,
    input  logic [pnit_pkg::PITCH_W-1:0]      i_pitch,
    input  logic [pnit_pkg::PROB_W-1:0]       i_onset_prob,
    input  logic [pnit_pkg::PROB_W-1:0]       i_frame_prob,
    input  logic [pnit_pkg::PROB_W-1:0]       i_volume_prob,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pnit_pkg::PITCH_W-1:0]      o_note_pitch,
    output logic [pnit_pkg::OUT_FRAME_W-1:0]  o_start_frame,
    output logic [pnit_pkg::OUT_FRAME_W-1:0]  o_end_frame,
    output logic [pnit_pkg::VEL_W-1:0]        o_velocity
);

    import pnit_pkg::*;

    localparam int IDX_W = (NUM_PITCHES > 1) ? $clog2(NUM_PITCHES) : 1;
    localparam logic [PITCH_W:0]     NUM_P_EXT  = (PITCH_W+1)'(NUM_PITCHES);
    localparam logic [PITCH_W-1:0]   LAST_PITCH = PITCH_W'(NUM_PITCHES - 1);
    localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};

    // configuration registers
    logic [PROB_W-1:0] r_prob_threshold;
    logic [VEL_W-1:0]  r_velocity_scale;
    logic [VEL_W-1:0]  r_velocity_offset;
    logic              cfg_wr;

    // input stage
    logic                   r_vld;
    logic                   r_start;
    logic [PITCH_W-1:0]     r_pitch;
    logic [PROB_W-1:0]      r_onset;
    logic [PROB_W-1:0]      r_frame;
    logic [PROB_W-1:0]      r_volume;
    logic [OUT_FRAME_W-1:0] r_rd_start;
    logic [VEL_W-1:0]       r_rd_vel;

    // per-pitch state
    logic [NUM_PITCHES-1:0] r_active,   n_active;
    logic [NUM_PITCHES-1:0] r_prev_low, n_prev_low;
    logic [FRAME_BITS-1:0]  r_frame_cnt, n_frame_cnt;
    logic [OUT_FRAME_W-1:0] mem_start [NUM_PITCHES];
    logic [VEL_W-1:0]       mem_vel   [NUM_PITCHES];

    // result register
    logic                   r_out_vld;
    logic [PITCH_W-1:0]     r_out_pitch;
    logic [OUT_FRAME_W-1:0] r_out_start;
    logic [OUT_FRAME_W-1:0] r_out_end;
    logic [VEL_W-1:0]       r_out_vel;

    // decision logic
    logic                   in_accept;
    logic                   fire;
    logic                   in_range;
    logic [IDX_W-1:0]       idx;
    logic                   act_cur;
    logic                   prev_low;
    logic                   onset_high;
    logic                   is_active;
    logic                   start_new;
    logic                   retrig;
    logic                   end_note;
    logic                   emit;
    logic                   mem_wr;
    logic                   fwd;
    logic [FRAME_BITS-1:0]  fc_eff;
    logic [OUT_FRAME_W+FRAME_BITS-1:0] fc_ext;
    logic [OUT_FRAME_W-1:0] fc_out;
    logic [14:0]            vel_prod;
    logic [VEL_W:0]         vel_sum;
    logic [VEL_W-1:0]       vel_new;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prob_threshold  <= THRESHOLD_RST;
            r_velocity_scale  <= SCALE_RST;
            r_velocity_offset <= OFFSET_RST;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_PROB_THRESHOLD:  r_prob_threshold  <= pwdata[PROB_W-1:0];
                REG_VELOCITY_SCALE:  r_velocity_scale  <= pwdata[VEL_W-1:0];
                REG_VELOCITY_OFFSET: r_velocity_offset <= pwdata[VEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_PROB_THRESHOLD:  prdata = APB_DATA_W'(r_prob_threshold);
            REG_VELOCITY_SCALE:  prdata = APB_DATA_W'(r_velocity_scale);
            REG_VELOCITY_OFFSET: prdata = APB_DATA_W'(r_velocity_offset);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Note decision for the item in the input stage
    // ------------------------------------------------------------------------
    assign in_range   = {1'b0, r_pitch} < NUM_P_EXT;
    assign idx        = r_pitch[IDX_W-1:0];
    // a start flag clears all note state before this item is looked at
    assign act_cur    = r_start ? 1'b0 : (in_range && r_active[idx]);
    assign prev_low   = r_start ? 1'b1 : (!in_range || r_prev_low[idx]);
    assign onset_high = r_onset > r_prob_threshold;
    assign is_active  = onset_high || (r_frame > r_prob_threshold);

    assign start_new  = in_range && is_active && !act_cur && onset_high;
    assign retrig     = in_range && is_active && act_cur && onset_high && prev_low;
    assign end_note   = in_range && !is_active && act_cur;
    assign emit       = retrig || end_note;
    assign mem_wr     = fire && (start_new || retrig);

    assign fc_eff     = r_start ? '0 : r_frame_cnt;
    assign fc_ext     = {{OUT_FRAME_W{1'b0}}, fc_eff};
    assign fc_out     = fc_ext[OUT_FRAME_W-1:0];

    assign vel_prod   = 15'(r_volume) * 15'(r_velocity_scale);
    assign vel_sum    = {1'b0, r_velocity_offset} + {1'b0, vel_prod[14:8]};
    assign vel_new    = vel_sum[VEL_W] ? VEL_MAX : vel_sum[VEL_W-1:0];

    // hold the stage only when a note is due and the result register is blocked
    assign fire       = r_vld && (!emit || !r_out_vld || i_out_ready);
    assign o_in_ready = !r_vld || fire;
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        n_active    = r_active;
        n_prev_low  = r_prev_low;
        n_frame_cnt = r_frame_cnt;
        if (fire) begin
            if (r_start) begin
                n_active    = '0;
                n_prev_low  = '1;
                n_frame_cnt = '0;
            end
            if (in_range) begin
                n_active[idx]   = act_cur ? is_active : start_new;
                n_prev_low[idx] = r_onset < r_prob_threshold;
                if (r_pitch == LAST_PITCH && fc_eff != FRAME_MAX) begin
                    n_frame_cnt = fc_eff + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_prev_low  <= '1;
            r_frame_cnt <= '0;
        end else begin
            r_active    <= n_active;
            r_prev_low  <= n_prev_low;
            r_frame_cnt <= n_frame_cnt;
        end
    end

    // ------------------------------------------------------------------------
    // Input stage and note memories
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_start  <= i_start_of_piece;
            r_pitch  <= i_pitch;
            r_onset  <= i_onset_prob;
            r_frame  <= i_frame_prob;
            r_volume <= i_volume_prob;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            mem_start[idx] <= fc_out;
            mem_vel[idx]   <= vel_new;
        end
    end

    // forward a write landing in the same cycle as the read of that pitch
    assign fwd = mem_wr && (idx == i_pitch[IDX_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (fwd) begin
                r_rd_start <= fc_out;
                r_rd_vel   <= vel_new;
            end else begin
                r_rd_start <= mem_start[i_pitch[IDX_W-1:0]];
                r_rd_vel   <= mem_vel[i_pitch[IDX_W-1:0]];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire && emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out_pitch <= r_pitch;
            r_out_start <= r_rd_start;
            r_out_end   <= fc_out;
            r_out_vel   <= r_rd_vel;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_note_pitch  = r_out_pitch;
    assign o_start_frame = r_out_start;
    assign o_end_frame   = r_out_end;
    assign o_velocity    = r_out_vel;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`include "piano_note_interval_tracker_macros.svh"

    `PNIT_ASSERT_NEXT(a_emit_lands, fire && emit, r_out_vld, "finished note not presented")
    `PNIT_ASSERT_NEXT(a_frame_mono, fire && !r_start,
                      r_frame_cnt >= $past(r_frame_cnt), "frame counter went back")
    `PNIT_ASSERT_NEXT(a_write_active, mem_wr, r_active[$past(idx)],
                      "note memory written for an inactive pitch")

endmodule
